[rtl/uart_dart_channel_registers_macros.svh]
// Assertion macros shared by the serial controller register files.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef UART_DART_CHANNEL_REGISTERS_MACROS_SVH
`define UART_DART_CHANNEL_REGISTERS_MACROS_SVH

// same-cycle implication
`define UDC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("udc assertion failed");

// next-cycle implication
`define UDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("udc assertion failed");

`endif

[rtl/udc_pkg.sv]
// Shared constants and types for the serial controller register block.
// No dependencies.
package udc_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   // action codes
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_RX    = 2'd2;

   // register offsets
   localparam logic [1:0] OFS_DATA   = 2'd0;
   localparam logic [1:0] OFS_CMD    = 2'd1;
   localparam logic [1:0] OFS_ENABLE = 2'd2;

   localparam logic [7:0] STATUS_FIXED    = 8'h64;
   localparam logic [7:0] STATUS_RX_AVAIL = 8'h01;
   localparam logic [1:0] CMD_TOP_CLEAR   = 2'b11;  // bits 7:6
   localparam logic [1:0] CMD_CHAN_A      = 2'b00;  // bits 3:2
   localparam logic [1:0] CMD_CHAN_B      = 2'b01;
   localparam int         EN_TX_BIT       = 1;      // enable mask 0x02
   localparam int         EN_RX_BIT       = 2;      // enable mask 0x04
   localparam logic [7:0] VEC_IDLE        = 8'h08;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } fifo_stat_type;

endpackage

[rtl/udc_channel_if.sv]
// Handshake interfaces for the request and response channels.
// No dependencies.
interface udc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] offset;
   logic [7:0] write_data;
   logic [7:0] rx_data;

   modport source (output valid, action, offset, write_data, rx_data, input ready);
   modport sink (input valid, action, offset, write_data, rx_data, output ready);
endinterface

interface udc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       tx_valid;
   logic [7:0] tx_data;
   logic       interrupt_pending;
   logic [7:0] interrupt_vector;
   logic       rx_overrun;

   modport source (output valid, read_data, tx_valid, tx_data, interrupt_pending,
                   interrupt_vector, rx_overrun, input ready);
   modport sink (input valid, read_data, tx_valid, tx_data, interrupt_pending,
                 interrupt_vector, rx_overrun, output ready);
endinterface

[rtl/udc_rx_fifo.sv]
// Receive FIFO: synchronous memory, registered read, pointers and count.
// Depends on udc_pkg and uart_dart_channel_registers_macros.svh.
`include "uart_dart_channel_registers_macros.svh"

module udc_rx_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  udc_pkg::fifo_ctl_type  ctl,
   input  logic [7:0]             push_data,
   output udc_pkg::fifo_stat_type stat,
   output logic [7:0]             pop_data
);
   import udc_pkg::*;

   logic [7:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       pop_data_ff;
   logic             do_push, do_pop;

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.one_left = (count_ff == CNT_W'(1));

   // requests beyond the fill level are dropped here
   assign do_push = ctl.push && !stat.full;
   assign do_pop  = ctl.pop && !stat.empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (do_pop) begin
         head_in  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage, written and read at most once per cycle; never the same item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_data;
      end
      if (do_pop) begin
         pop_data_ff <= mem[head_ff];
      end
   end

   assign pop_data = pop_data_ff;

   `UDC_ASSERT_IMPL(a_full_not_empty, stat.full, !stat.empty)
   `UDC_ASSERT_NEXT(a_push_fills, do_push, !stat.empty)
   `UDC_ASSERT_NEXT(a_last_pop_empties, do_pop && stat.one_left, stat.empty)

endmodule

[rtl/uart_dart_channel_registers.sv]
// Top level of the serial controller register block.
// Depends on udc_pkg, udc_channel_if, udc_rx_fifo and the assertion macros.
//
// channel   dir  handshake        payload
// req_chan  in   valid / ready    action, offset, write_data, rx_data
// rsp_chan  out  valid / ready    read_data, tx_*, interrupt_*, rx_overrun
// csr       in   write enable     vector_base byte
//
// One transfer in per cycle while req_chan.ready is high; result from the output register in the next cycle.
// req_chan.ready is high whenever the output register is empty or being drained.
// Popped bytes come from the FIFO memory's registered read port in the same
// cycle the output register loads, so a read is no slower than other transfers.
// Synchronous active-high reset clears flags, pointers and count; no clear pass.
`include "uart_dart_channel_registers_macros.svh"

module uart_dart_channel_registers (
   input  logic        clock,
   input  logic        reset,
   udc_req_if.sink     req_chan,
   udc_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import udc_pkg::*;

   // configuration
   logic [7:0] vector_base_ff;

   // controller state
   logic       chan_a_ff, chan_a_in;
   logic [7:0] enables_ff, enables_in;
   logic       overrun_ff, overrun_in;
   logic       irq_ff, irq_in;

   // output register
   logic       rsp_valid_ff;
   logic       rsp_pop_ff;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_tx_valid_ff;
   logic [7:0] rsp_tx_data_ff;
   logic [7:0] rsp_vector_ff;

   logic          accept;
   logic          is_read, is_write, is_rx;
   logic          wr_data, wr_cmd, wr_enable;
   logic          pop_req, pop_done, push_done;
   logic          count_nz_next;
   logic          irq_recalc;
   fifo_ctl_type  fifo_ctl;
   fifo_stat_type fifo_stat;
   logic [7:0]    fifo_pop_data;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_read  = (req_chan.action == ACT_READ);
   assign is_write = (req_chan.action == ACT_WRITE);
   assign is_rx    = (req_chan.action == ACT_RX);

   assign wr_data   = is_write && (req_chan.offset == OFS_DATA);
   assign wr_cmd    = is_write && (req_chan.offset == OFS_CMD);
   assign wr_enable = is_write && (req_chan.offset == OFS_ENABLE);

   // offsets 0 and 1 read the data port
   assign pop_req = is_read && !req_chan.offset[1];

   assign fifo_ctl.push = accept && is_rx;
   assign fifo_ctl.pop  = accept && pop_req;

   udc_rx_fifo u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data (req_chan.rx_data),
      .stat      (fifo_stat),
      .pop_data  (fifo_pop_data)
   );

   assign pop_done  = fifo_ctl.pop && !fifo_stat.empty;
   assign push_done = fifo_ctl.push && !fifo_stat.full;

   // FIFO occupancy after this transfer; push and pop never share a transfer
   always_comb begin
      if (push_done) begin
         count_nz_next = 1'b1;
      end else if (pop_done) begin
         count_nz_next = !fifo_stat.one_left;
      end else begin
         count_nz_next = !fifo_stat.empty;
      end
   end

   always_comb begin
      chan_a_in  = chan_a_ff;
      enables_in = enables_ff;
      overrun_in = overrun_ff;
      if (accept && wr_cmd) begin
         if (req_chan.write_data[7:6] == CMD_TOP_CLEAR) begin
            overrun_in = 1'b0;
         end
         case (req_chan.write_data[3:2])
            CMD_CHAN_A: chan_a_in = 1'b1;
            CMD_CHAN_B: chan_a_in = 1'b0;
            default:    chan_a_in = chan_a_ff;
         endcase
      end
      if (accept && wr_enable && chan_a_ff) begin
         enables_in = req_chan.write_data;
      end
      if (fifo_ctl.push && fifo_stat.full) begin
         overrun_in = 1'b1;
      end
   end

   // interrupt request is re-evaluated only on these events
   assign irq_recalc = pop_done || fifo_ctl.push || (accept && (wr_data || wr_enable));

   always_comb begin
      irq_in = irq_ff;
      if (irq_recalc) begin
         irq_in = chan_a_ff && (enables_in[EN_TX_BIT] ||
                                (enables_in[EN_RX_BIT] && count_nz_next));
      end
   end

   always_comb begin
      rsp_read_data_in = '0;
      if (is_read && req_chan.offset[1]) begin
         rsp_read_data_in = STATUS_FIXED | (fifo_stat.empty ? 8'h00 : STATUS_RX_AVAIL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_base_ff <= '0;
         chan_a_ff      <= 1'b1;
         enables_ff     <= '0;
         overrun_ff     <= 1'b0;
         irq_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            vector_base_ff <= csr_write_data;
         end
         chan_a_ff  <= chan_a_in;
         enables_ff <= enables_in;
         overrun_ff <= overrun_in;
         irq_ff     <= irq_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pop_ff       <= pop_done;
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_tx_valid_ff  <= wr_data;
         rsp_tx_data_ff   <= wr_data ? req_chan.write_data : 8'h00;
         rsp_vector_ff    <= vector_base_ff | (irq_in ? 8'h00 : VEC_IDLE);
      end
   end

   // popped byte arrives from the FIFO read register alongside the rest
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.read_data         = rsp_pop_ff ? fifo_pop_data : rsp_read_data_ff;
   assign rsp_chan.tx_valid          = rsp_tx_valid_ff;
   assign rsp_chan.tx_data           = rsp_tx_data_ff;
   assign rsp_chan.interrupt_pending = irq_ff;
   assign rsp_chan.interrupt_vector  = rsp_vector_ff;
   assign rsp_chan.rx_overrun        = overrun_ff;

   `UDC_ASSERT_NEXT(a_overrun_on_full_push, fifo_ctl.push && fifo_stat.full, overrun_ff)
   `UDC_ASSERT_IMPL(a_tx_no_read_data, rsp_valid_ff && rsp_tx_valid_ff,
      rsp_chan.read_data == 8'h00)
   `UDC_ASSERT_IMPL(a_vector_tracks_irq, rsp_valid_ff,
      rsp_vector_ff[3] == (!irq_ff || vector_base_ff[3]))

endmodule

[dv/udc_reg_checker.sv]
// Checker for the serial controller register block: watches both channels and
// the csr port, predicts each response and compares it field by field.
// Depends on udc_pkg.
`timescale 1ns / 1ps

module udc_reg_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [1:0] req_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_rx_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_read_data,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_data,
   input  logic       rsp_interrupt_pending,
   input  logic [7:0] rsp_interrupt_vector,
   input  logic       rsp_rx_overrun,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         outstanding,
   output int         checked_count,
   output int         overrun_count
);
   import udc_pkg::*;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       irq;
      logic [7:0] vector;
      logic       overrun;
   } reg_result_type;

   // shadow of the block's registers
   logic [7:0]     vec_base;
   logic           chan_a;
   logic [7:0]     rx_mem [FIFO_DEPTH];
   int             rx_cnt;
   int             rx_head;
   logic           ovr;
   logic [7:0]     irq_en;
   logic           irq;
   reg_result_type expected_results[$];

   function automatic logic irq_request();
      return chan_a && (irq_en[EN_TX_BIT] || (irq_en[EN_RX_BIT] && rx_cnt > 0));
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      reg_result_type want;
      reg_result_type nxt;
      if (reset) begin
         vec_base = '0;
         chan_a   = 1'b1;
         rx_cnt   = 0;
         rx_head  = 0;
         ovr      = 1'b0;
         irq_en   = '0;
         irq      = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_write_enable)
            vec_base = csr_write_data;

         // response side first: its expectation was queued on an earlier edge
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h", $time,
                        rsp_read_data);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("read_data", want.read_data, rsp_read_data);
               compare_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, rsp_tx_valid});
               compare_field("tx_data", want.tx_data, rsp_tx_data);
               compare_field("interrupt_pending", {7'd0, want.irq},
                             {7'd0, rsp_interrupt_pending});
               compare_field("interrupt_vector", want.vector, rsp_interrupt_vector);
               compare_field("rx_overrun", {7'd0, want.overrun}, {7'd0, rsp_rx_overrun});
               checked_count++;
            end
         end

         if (req_valid && req_ready) begin
            nxt = '0;
            case (req_action)
               ACT_READ: begin
                  if (req_offset == OFS_DATA || req_offset == OFS_CMD) begin
                     if (rx_cnt > 0) begin
                        nxt.read_data = rx_mem[rx_head];
                        rx_head = (rx_head + 1) % FIFO_DEPTH;
                        rx_cnt--;
                        irq = irq_request();
                     end
                  end else begin
                     nxt.read_data = STATUS_FIXED | ((rx_cnt > 0) ? STATUS_RX_AVAIL : 8'h00);
                  end
               end
               ACT_WRITE: begin
                  case (req_offset)
                     OFS_DATA: begin
                        nxt.tx_valid = 1'b1;
                        nxt.tx_data  = req_write_data;
                        irq = irq_request();
                     end
                     OFS_CMD: begin
                        if (req_write_data[7:6] == CMD_TOP_CLEAR)
                           ovr = 1'b0;
                        if (req_write_data[3:2] == CMD_CHAN_B)
                           chan_a = 1'b0;
                        else if (req_write_data[3:2] == CMD_CHAN_A)
                           chan_a = 1'b1;
                     end
                     OFS_ENABLE: begin
                        if (chan_a)
                           irq_en = req_write_data;
                        irq = irq_request();
                     end
                     default: ;
                  endcase
               end
               ACT_RX: begin
                  if (rx_cnt < FIFO_DEPTH) begin
                     rx_mem[(rx_head + rx_cnt) % FIFO_DEPTH] = req_rx_data;
                     rx_cnt++;
                  end else begin
                     ovr = 1'b1;
                     overrun_count++;
                  end
                  irq = irq_request();
               end
               default: ;
            endcase
            nxt.irq     = irq;
            nxt.vector  = vec_base | (irq ? 8'h00 : VEC_IDLE);
            nxt.overrun = ovr;
            expected_results = {expected_results, nxt};
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[dv/uart_dart_channel_registers_tb.sv]
// Top of the serial controller register testbench: clock, reset, stimulus and verdict.
// Depends on udc_pkg, udc_channel_if, the block itself and udc_reg_checker.
`timescale 1ns / 1ps

module uart_dart_channel_registers_tb;
   import udc_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] ACT_SPARE   = 2'd3;   // unused action, block does nothing
   localparam logic [1:0] OFS_STAT_HI = 2'd3;   // second status offset, writes ignored

   localparam int NUM_PHASES   = 5;
   localparam int RAND_PER_PH  = 310;
   localparam int CYCLE_LIMIT  = 200000;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   int  fail_count;
   int  outstanding;
   int  checked_count;
   int  overrun_count;
   int  cycles;
   bit  calm;         // set for the last phase: no idling on either side

   udc_req_if req_chan ();
   udc_rsp_if rsp_chan ();

   uart_dart_channel_registers u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   udc_reg_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_chan.valid),
      .req_ready             (req_chan.ready),
      .req_action            (req_chan.action),
      .req_offset            (req_chan.offset),
      .req_write_data        (req_chan.write_data),
      .req_rx_data           (req_chan.rx_data),
      .rsp_valid             (rsp_chan.valid),
      .rsp_ready             (rsp_chan.ready),
      .rsp_read_data         (rsp_chan.read_data),
      .rsp_tx_valid          (rsp_chan.tx_valid),
      .rsp_tx_data           (rsp_chan.tx_data),
      .rsp_interrupt_pending (rsp_chan.interrupt_pending),
      .rsp_interrupt_vector  (rsp_chan.interrupt_vector),
      .rsp_rx_overrun        (rsp_chan.rx_overrun),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .fail_count            (fail_count),
      .outstanding           (outstanding),
      .checked_count         (checked_count),
      .overrun_count         (overrun_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // response side back-pressure: random stalls, none once calm
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (calm) begin
            hold = 0;
            rsp_chan.ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 2);   // stall starts now; hold adds a random extension
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // One transfer on the request channel. An optional idle burst comes first;
   // valid stays high across back-to-back transfers so it never toggles in a step.
   task automatic send_item(input logic [1:0] act, input logic [1:0] ofs,
                            input logic [7:0] wd, input logic [7:0] rd);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.offset     <= ofs;
      req_chan.write_data <= wd;
      req_chan.rx_data    <= rd;
      // ready seen right after the edge is the value that edge used
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // stop sending and let every predicted response come back
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      // checker count settles after the edge; look at it mid-cycle
      do @(negedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);   // a little slack after the last response
   endtask

   // vector_base written only while the block is idle
   task automatic set_vector_base(input logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random item. fill mode leans on received bytes so the FIFO fills and
   // overruns; drain mode leans on data reads so it empties again.
   task automatic random_item(input bit fill);
      logic [1:0] act;
      logic [1:0] ofs;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 2)
         act = ACT_SPARE;
      else if (fill)
         act = (pick < 72) ? ACT_RX : (pick < 82) ? ACT_READ : ACT_WRITE;
      else
         act = (pick < 62) ? ACT_READ : (pick < 77) ? ACT_RX : ACT_WRITE;
      ofs = 2'($urandom_range(0, 3));
      // data reads are what drains the queue; keep status reads a minority
      if (act == ACT_READ && $urandom_range(0, 3) != 0)
         ofs = 2'($urandom_range(0, 1));
      send_item(act, ofs, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      logic [7:0] vec_list [NUM_PHASES];
      vec_list = '{8'h00, 8'hFF, 8'h00, 8'h08, 8'h00};
      vec_list[2] = 8'($urandom_range(0, 255));
      vec_list[4] = 8'($urandom_range(0, 255));

      calm = 1'b0;
      reset = 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= 8'h00;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_READ;
      req_chan.offset     <= OFS_DATA;
      req_chan.write_data <= 8'h00;
      req_chan.rx_data    <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_responses();
         set_vector_base(vec_list[ph]);
         calm = (ph == NUM_PHASES - 1);

         if (ph == 0) begin
            // empty queue: data reads return 0, status shows nothing held
            send_item(ACT_READ, OFS_DATA, 8'h00, 8'h00);
            send_item(ACT_READ, OFS_CMD, 8'hFF, 8'hFF);
            send_item(ACT_READ, OFS_ENABLE, 8'h00, 8'h00);
            send_item(ACT_READ, OFS_STAT_HI, 8'h00, 8'h00);
            // transmit extremes
            send_item(ACT_WRITE, OFS_DATA, 8'h00, 8'h00);
            send_item(ACT_WRITE, OFS_DATA, 8'hFF, 8'h00);
            // tx enable raises the request; rx enable alone needs a held byte
            send_item(ACT_WRITE, OFS_ENABLE, 8'h02, 8'h00);
            send_item(ACT_WRITE, OFS_ENABLE, 8'h04, 8'h00);
            send_item(ACT_RX, OFS_DATA, 8'h00, 8'h00);
            send_item(ACT_RX, OFS_STAT_HI, 8'h00, 8'hFF);
            send_item(ACT_READ, OFS_ENABLE, 8'h00, 8'h00);
            send_item(ACT_READ, OFS_DATA, 8'h00, 8'h00);
            send_item(ACT_READ, OFS_CMD, 8'h00, 8'h00);
            // channel B: enable write stores nothing but recomputes the request
            send_item(ACT_WRITE, OFS_CMD, 8'h04, 8'h00);
            send_item(ACT_WRITE, OFS_ENABLE, 8'hFF, 8'h00);
            // channel field 10 and 11 keep the current channel
            send_item(ACT_WRITE, OFS_CMD, 8'h08, 8'h00);
            send_item(ACT_WRITE, OFS_CMD, 8'h0C, 8'h00);
            send_item(ACT_WRITE, OFS_CMD, 8'hC0, 8'h00);
            send_item(ACT_WRITE, OFS_CMD, 8'h00, 8'h00);
            // ignored write at offset 3, unused action, command with all bits set
            send_item(ACT_WRITE, OFS_STAT_HI, 8'hAA, 8'h55);
            send_item(ACT_SPARE, OFS_STAT_HI, 8'hFF, 8'hFF);
            send_item(ACT_WRITE, OFS_CMD, 8'hFF, 8'h00);
         end

         for (int i = 0; i < RAND_PER_PH; i++) begin
            // hold-off: once, the sender waits for every response mid-phase
            if (ph == 2 && i == RAND_PER_PH / 2)
               drain_responses();
            random_item(((i / 40) % 2) == 0);
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);

      $display("Summary: %0d transfers checked over %0d vector_base settings,",
               checked_count, NUM_PHASES);
      $display("  both channels, FIFO fill and drain, %0d pushes into a full FIFO.",
               overrun_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
